// ===== rtl/binary_run_length_encoder_defines.svh =====
// Assertion macros used by the encoder top level.
`ifndef BINARY_RUN_LENGTH_ENCODER_DEFINES_SVH
`define BINARY_RUN_LENGTH_ENCODER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define BRLE_ASSERT_SAME(label, ck, rstn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define BRLE_ASSERT_NEXT(label, ck, rstn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/brle_pkg.sv =====
`timescale 1ns / 1ps
package brle_pkg;

	localparam int MAX_COUNT_BITS = 16;
	localparam int GAMMA_W        = 5;
	localparam int WORD_W         = 16;
	localparam int MAX_WORDS      = 3;
	localparam int CNT_W          = 2;
	localparam int IDX_W          = 2;

	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 5'd8;

	// Word kinds
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_COUNT  = 1'b1;

	// Register indexes
	localparam logic REG_GAMMA = 1'b0;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] value;
		logic              last;
	} word_t;

	// Words produced by one input item, lowest entry sent first
	typedef struct packed {
		logic                      load;
		logic [CNT_W-1:0]          cnt;
		word_t [MAX_WORDS-1:0]     words;
	} word_set_t;

	// Largest count for a given width, width clamped to 1..MAX_COUNT_BITS
	function automatic logic [WORD_W-1:0] max_count(input logic [GAMMA_W-1:0] g);
		logic [GAMMA_W-1:0] gc;
		logic [WORD_W:0]    one_sh;
		gc = g;
		if (gc == '0)
			gc = GAMMA_W'(1);
		if (gc > GAMMA_W'(MAX_COUNT_BITS))
			gc = GAMMA_W'(MAX_COUNT_BITS);
		one_sh = (WORD_W+1)'(1) << gc;
		return WORD_W'(one_sh - (WORD_W+1)'(1));
	endfunction

endpackage

// ===== rtl/binary_run_length_encoder.sv =====
// Path: an item is registered in the input stage on acceptance, and its words are then loaded
// into the output word buffer, from which they are offered.
// Throughput: one bit per cycle while each bit yields at most one word and the output accepts each word.
// A bit that yields two or three words holds the input stage until its word buffer drains.
// Reset (arst_n low, asynchronous): no stream open, buffer empty, count width 8.
`timescale 1ns / 1ps
`include "binary_run_length_encoder_defines.svh"
module binary_run_length_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] bit_in, [7:1] zero fill
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] word_value
	output logic        m_axis_tuser,  // [0] word_kind
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import brle_pkg::*;

	logic [GAMMA_W-1:0] gamma_bits;
	logic               buf_free;
	word_set_t          word_set;
	word_t              out_word;

	brle_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.gamma_bits (gamma_bits)
	);

	brle_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_bit     (s_axis_tdata[0]),
		.in_last    (s_axis_tlast),
		.gamma_bits (gamma_bits),
		.buf_free   (buf_free),
		.set_out    (word_set)
	);

	brle_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.set_in    (word_set),
		.buf_free  (buf_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (out_word)
	);

	assign m_axis_tdata = out_word.value;
	assign m_axis_tuser = out_word.kind;
	assign m_axis_tlast = out_word.last;

	// A header word never closes a stream
	`BRLE_ASSERT_SAME(a_header_not_last, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_HEADER, !m_axis_tlast)
	// A word set loads only into a free buffer
	`BRLE_ASSERT_SAME(a_load_when_free, clk, arst_n, word_set.load, buf_free)
	// A loaded word set is offered next cycle
	`BRLE_ASSERT_NEXT(a_load_offers, clk, arst_n, word_set.load, m_axis_tvalid)

endmodule

// ===== rtl/brle_cfg.sv =====
`timescale 1ns / 1ps
module brle_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output logic [brle_pkg::GAMMA_W-1:0]   gamma_bits
);
	import brle_pkg::*;

	logic [GAMMA_W-1:0] gamma_q;

	assign pready     = 1'b1;
	assign gamma_bits = gamma_q;

	// Write the count width on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAMMA) begin
			gamma_q <= pwdata[GAMMA_W-1:0];
		end
	end

	// Read back the register
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_GAMMA)
			prdata = {{(32-GAMMA_W){1'b0}}, gamma_q};
	end

endmodule

// ===== rtl/brle_core.sv =====
`timescale 1ns / 1ps
module brle_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_bit,
	input  logic                         in_last,
	input  logic [brle_pkg::GAMMA_W-1:0] gamma_bits,
	input  logic                         buf_free,
	output brle_pkg::word_set_t          set_out
);
	import brle_pkg::*;

	logic              valid_s1;
	logic              bit_s1;
	logic              last_s1;
	logic              started_q;
	logic              prev_q;
	logic [WORD_W-1:0] run_q;

	logic              fire;
	logic              load_c;
	logic [WORD_W-1:0] m;
	word_set_t         set_c;
	logic              started_n;
	logic              prev_n;
	logic [WORD_W-1:0] run_n;

	assign m        = max_count(gamma_bits);
	assign fire     = valid_s1 && (set_c.cnt == '0 || buf_free);
	assign in_ready = !valid_s1 || fire;
	assign load_c   = fire && (set_c.cnt != '0);

	// Form the words of the held item and the next run state
	always_comb begin
		logic [CNT_W-1:0] n;
		n         = '0;
		set_c     = '0;
		started_n = started_q;
		prev_n    = prev_q;
		run_n     = run_q;
		if (!started_q) begin
			set_c.words[n] = '{kind: KIND_HEADER, value: WORD_W'(bit_s1), last: 1'b0};
			n         = n + CNT_W'(1);
			started_n = 1'b1;
			prev_n    = bit_s1;
			run_n     = WORD_W'(1);
		end else if (bit_s1 == prev_q) begin
			if (run_q >= m) begin
				set_c.words[n] = '{kind: KIND_COUNT, value: m, last: 1'b0};
				n = n + CNT_W'(1);
				set_c.words[n] = '{kind: KIND_COUNT, value: '0, last: 1'b0};
				n = n + CNT_W'(1);
				run_n = WORD_W'(1);
			end else begin
				run_n = run_q + WORD_W'(1);
			end
		end else begin
			set_c.words[n] = '{kind: KIND_COUNT, value: (run_q > m) ? m : run_q,
				last: 1'b0};
			n      = n + CNT_W'(1);
			prev_n = bit_s1;
			run_n  = WORD_W'(1);
		end
		// Flush the final run
		if (last_s1) begin
			set_c.words[n] = '{kind: KIND_COUNT, value: (run_n > m) ? m : run_n,
				last: 1'b1};
			n         = n + CNT_W'(1);
			started_n = 1'b0;
			prev_n    = 1'b0;
			run_n     = '0;
		end
		set_c.cnt = n;
	end

	// Attach the load strobe to the word set
	always_comb begin
		set_out      = set_c;
		set_out.load = load_c;
	end

	// Hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bit_s1  <= in_bit;
			last_s1 <= in_last;
		end
	end

	// Advance the run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			prev_q    <= 1'b0;
			run_q     <= '0;
		end else if (fire) begin
			started_q <= started_n;
			prev_q    <= prev_n;
			run_q     <= run_n;
		end
	end

endmodule

// ===== rtl/brle_outbuf.sv =====
`timescale 1ns / 1ps
module brle_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  brle_pkg::word_set_t set_in,
	output logic                buf_free,
	output logic                out_valid,
	input  logic                out_ready,
	output brle_pkg::word_t     out_word
);
	import brle_pkg::*;

	word_t [MAX_WORDS-1:0] words_q;
	logic  [CNT_W-1:0]     cnt_q;
	logic  [IDX_W-1:0]     idx_q;
	logic                  pop;

	assign out_valid = cnt_q != '0;
	assign out_word  = words_q[idx_q];
	assign pop       = out_valid && out_ready;
	assign buf_free  = (cnt_q == '0) || (cnt_q == CNT_W'(1) && pop);

	// Load a new word set or step through the held one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (set_in.load) begin
			cnt_q <= set_in.cnt;
			idx_q <= '0;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (set_in.load)
			words_q <= set_in.words;
	end

endmodule
